// ===== design/mrfe_pkg.sv =====
// shared types, constants and the crc byte update for the modbus rtu frame engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mrfe_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [7:0] LIGHT_SENSOR_ID_RESET = 8'd2;

   // request and result codes
   localparam logic REQ_SEND = 1'b0;
   localparam logic REQ_RX_BYTE = 1'b1;
   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // receive frame positions
   localparam logic [2:0] RX_IDX_DATA_HI = 3'd4;
   localparam logic [2:0] RX_IDX_DATA_LO = 3'd5;
   localparam logic [2:0] RX_IDX_CRC_LO = 3'd6;
   localparam logic [2:0] RX_IDX_CRC_HI = 3'd7;

   // transmit frame positions
   localparam logic [2:0] TX_IDX_ADDR = 3'd0;
   localparam logic [2:0] TX_IDX_FUNC = 3'd1;
   localparam logic [2:0] TX_IDX_REG_HI = 3'd2;
   localparam logic [2:0] TX_IDX_REG_LO = 3'd3;
   localparam logic [2:0] TX_IDX_VAL_HI = 3'd4;
   localparam logic [2:0] TX_IDX_VAL_LO = 3'd5;
   localparam logic [2:0] TX_IDX_CRC_LO = 3'd6;
   localparam logic [2:0] TX_IDX_CRC_HI = 3'd7;

   // one queued job for the back end: a frame to send or a finished verdict
   typedef struct packed {
      logic        is_verdict;
      logic [7:0]  dev_addr;
      logic [7:0]  func_code;
      logic [15:0] reg_addr;
      logic [15:0] reg_value;
      logic        crc_ok;
      logic [15:0] reading;
      logic        reading_valid;
   } cmd_type;

   // crc-16/modbus update by one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] c;
      c = acc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/modbus_rtu_frame_engine_unit.sv =====
// Modbus RTU master frame engine for single-register exchanges. A send request
// (req_type 0) comes out as eight transmit words, one per cycle while the result
// register is free or being popped: address, function, register and value high
// byte first, then the CRC-16/MODBUS low byte first; it also restarts the receive
// frame. Received bytes (req_type 1) are taken one per cycle as room allows and give
// nothing until the eighth, which yields one verdict word with the crc check, bytes
// four and five as the reading, and whether the last request addressed the light
// sensor. Input words are taken every cycle while the job queue (QUEUE_DEPTH entries)
// has room; a send request holds the serializer until its eighth word is out, and no
// new job is taken before then. The first result of a word passes through the job
// queue and then the result register before it is on the result ports. Depends on
// mrfe_pkg, mrfe_front, mrfe_fifo and mrfe_back.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_frame_engine_unit #(
   parameter int unsigned QUEUE_DEPTH = mrfe_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_dev_addr,
   input  wire logic [7:0]  req_func_code,
   input  wire logic [15:0] req_reg_addr,
   input  wire logic [15:0] req_reg_value,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        empty,
   input  wire logic        pop,
   output      logic        rsp_out_kind,
   output      logic [7:0]  rsp_tx_byte,
   output      logic        rsp_last,
   output      logic        rsp_crc_ok,
   output      logic [15:0] rsp_reading,
   output      logic        rsp_reading_valid,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);
   import mrfe_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    front_push;
   logic    queue_empty;
   logic    back_pop;

   mrfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_type      (req_type),
      .req_dev_addr  (req_dev_addr),
      .req_func_code (req_func_code),
      .req_reg_addr  (req_reg_addr),
      .req_reg_value (req_reg_value),
      .req_rx_byte   (req_rx_byte),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .cmd_push      (front_push),
      .cmd           (front_cmd)
   );

   mrfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_cmd),
      .rd_en   (back_pop),
      .rd_data (queue_cmd),
      .full    (full),
      .empty   (queue_empty)
   );

   mrfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_empty         (queue_empty),
      .job               (queue_cmd),
      .job_pop           (back_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last          (rsp_last),
      .rsp_crc_ok        (rsp_crc_ok),
      .rsp_reading       (rsp_reading),
      .rsp_reading_valid (rsp_reading_valid)
   );

endmodule

`default_nettype wire

// ===== design/mrfe_front.sv =====
// front end: takes request and receive words, tracks the receive frame and its crc,
// and queues send jobs and verdicts; depends on mrfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrfe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic             full,
   input  wire logic             req_type,
   input  wire logic [7:0]       req_dev_addr,
   input  wire logic [7:0]       req_func_code,
   input  wire logic [15:0]      req_reg_addr,
   input  wire logic [15:0]      req_reg_value,
   input  wire logic [7:0]       req_rx_byte,
   input  wire logic             csr_we,
   input  wire logic [7:0]       csr_wdata,
   output      logic             cmd_push,
   output      mrfe_pkg::cmd_type cmd
);
   import mrfe_pkg::*;

   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [2:0]  rx_count_ff, rx_count_in;
   logic [15:0] rx_data_ff, rx_data_in;
   logic [7:0]  rx_crc_low_ff, rx_crc_low_in;
   logic [7:0]  last_target_ff, last_target_in;
   logic [7:0]  light_sensor_id_ff;
   logic        accept;

   assign accept = push && !full;

   always_comb begin
      rx_crc_in      = rx_crc_ff;
      rx_count_in    = rx_count_ff;
      rx_data_in     = rx_data_ff;
      rx_crc_low_in  = rx_crc_low_ff;
      last_target_in = last_target_ff;
      cmd_push       = 1'b0;

      cmd.is_verdict    = (req_type == REQ_RX_BYTE);
      cmd.dev_addr      = req_dev_addr;
      cmd.func_code     = req_func_code;
      cmd.reg_addr      = req_reg_addr;
      cmd.reg_value     = req_reg_value;
      cmd.crc_ok        = (rx_crc_low_ff == rx_crc_ff[7:0]) &&
                          (req_rx_byte == rx_crc_ff[15:8]);
      cmd.reading       = rx_data_ff;
      cmd.reading_valid = (last_target_ff == light_sensor_id_ff);

      if (accept) begin
         if (req_type == REQ_SEND) begin
            cmd_push       = 1'b1;
            last_target_in = req_dev_addr;
            rx_crc_in      = CRC_INIT;
            rx_count_in    = '0;
            rx_data_in     = '0;
            rx_crc_low_in  = '0;
         end else begin
            if (rx_count_ff < RX_IDX_CRC_LO) begin
               rx_crc_in = crc_feed(rx_crc_ff, req_rx_byte);
            end
            if (rx_count_ff == RX_IDX_DATA_HI) begin
               rx_data_in = {req_rx_byte, rx_data_ff[7:0]};
            end else if (rx_count_ff == RX_IDX_DATA_LO) begin
               rx_data_in = {rx_data_ff[15:8], req_rx_byte};
            end else if (rx_count_ff == RX_IDX_CRC_LO) begin
               rx_crc_low_in = req_rx_byte;
            end
            if (rx_count_ff == RX_IDX_CRC_HI) begin
               // verdict word, receive side starts over
               cmd_push      = 1'b1;
               rx_crc_in     = CRC_INIT;
               rx_count_in   = '0;
               rx_data_in    = '0;
               rx_crc_low_in = '0;
            end else begin
               rx_count_in = rx_count_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_crc_ff          <= CRC_INIT;
         rx_count_ff        <= '0;
         rx_data_ff         <= '0;
         rx_crc_low_ff      <= '0;
         last_target_ff     <= '0;
         light_sensor_id_ff <= LIGHT_SENSOR_ID_RESET;
      end else begin
         rx_crc_ff      <= rx_crc_in;
         rx_count_ff    <= rx_count_in;
         rx_data_ff     <= rx_data_in;
         rx_crc_low_ff  <= rx_crc_low_in;
         last_target_ff <= last_target_in;
         if (csr_we) begin
            light_sensor_id_ff <= csr_wdata;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/mrfe_fifo.sv =====
// short job queue between the front and back ends
// depends on mrfe_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none

module mrfe_fifo #(
   parameter int unsigned DEPTH = mrfe_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire mrfe_pkg::cmd_type wr_data,
   input  wire logic              rd_en,
   output      mrfe_pkg::cmd_type rd_data,
   output      logic              full,
   output      logic              empty
);
   import mrfe_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mrfe_back.sv =====
// back end: serializes send jobs into eight frame bytes with a running crc,
// and passes verdicts through to the result register; depends on mrfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrfe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_empty,
   input  wire mrfe_pkg::cmd_type job,
   output      logic              job_pop,
   output      logic              empty,
   input  wire logic              pop,
   output      logic              rsp_out_kind,
   output      logic [7:0]        rsp_tx_byte,
   output      logic              rsp_last,
   output      logic              rsp_crc_ok,
   output      logic [15:0]       rsp_reading,
   output      logic              rsp_reading_valid
);
   import mrfe_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   state_type   state_ff, state_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   cmd_type     cmd_ff, cmd_in;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        ok_ff, ok_in;
   logic [15:0] reading_ff, reading_in;
   logic        valid_ff, valid_in;
   logic        advance;
   logic [7:0]  cur_byte;

   function automatic logic [7:0] frame_byte(input logic [2:0] idx, input cmd_type c,
                                             input logic [15:0] crc);
      logic [7:0] b;
      unique case (idx)
         TX_IDX_ADDR:   b = c.dev_addr;
         TX_IDX_FUNC:   b = c.func_code;
         TX_IDX_REG_HI: b = c.reg_addr[15:8];
         TX_IDX_REG_LO: b = c.reg_addr[7:0];
         TX_IDX_VAL_HI: b = c.reg_value[15:8];
         TX_IDX_VAL_LO: b = c.reg_value[7:0];
         TX_IDX_CRC_LO: b = crc[7:0];
         TX_IDX_CRC_HI: b = crc[15:8];
         default:       b = '0;
      endcase
      return b;
   endfunction

   // the result register may reload when it is empty or being taken
   assign advance  = !out_valid_ff || pop;
   assign empty    = !out_valid_ff;
   assign cur_byte = frame_byte(idx_ff, cmd_ff, crc_ff);

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      cmd_in       = cmd_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      ok_in        = ok_ff;
      reading_in   = reading_ff;
      valid_in     = valid_ff;
      job_pop      = 1'b0;

      if (advance) begin
         out_valid_in = 1'b0;
         unique case (state_ff)
            ST_SEND: begin
               out_valid_in = 1'b1;
               kind_in      = KIND_TX;
               byte_in      = cur_byte;
               last_in      = (idx_ff == TX_IDX_CRC_HI);
               ok_in        = 1'b0;
               reading_in   = '0;
               valid_in     = 1'b0;
               if (idx_ff < TX_IDX_CRC_LO) begin
                  crc_in = crc_feed(crc_ff, cur_byte);
               end
               idx_in = idx_ff + 3'd1;
               if (idx_ff == TX_IDX_CRC_HI) begin
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (!job_empty) begin
                  job_pop      = 1'b1;
                  out_valid_in = 1'b1;
                  if (job.is_verdict) begin
                     kind_in    = KIND_VERDICT;
                     byte_in    = '0;
                     last_in    = 1'b1;
                     ok_in      = job.crc_ok;
                     reading_in = job.reading;
                     valid_in   = job.reading_valid;
                  end else begin
                     // first frame byte goes out as the job is taken
                     kind_in    = KIND_TX;
                     byte_in    = job.dev_addr;
                     last_in    = 1'b0;
                     ok_in      = 1'b0;
                     reading_in = '0;
                     valid_in   = 1'b0;
                     crc_in     = crc_feed(CRC_INIT, job.dev_addr);
                     idx_in     = TX_IDX_FUNC;
                     cmd_in     = job;
                     state_in   = ST_SEND;
                  end
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      crc_ff     <= crc_in;
      cmd_ff     <= cmd_in;
      kind_ff    <= kind_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      ok_ff      <= ok_in;
      reading_ff <= reading_in;
      valid_ff   <= valid_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_out_kind      = kind_ff;
   assign rsp_tx_byte       = byte_ff;
   assign rsp_last          = last_ff;
   assign rsp_crc_ok        = ok_ff;
   assign rsp_reading       = reading_ff;
   assign rsp_reading_valid = valid_ff;

endmodule

`default_nettype wire
